### design/upper_envelope_line_table_unit_defines.svh
// Assertion macros shared by the upper envelope line table RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef UPPER_ENVELOPE_LINE_TABLE_UNIT_DEFINES_SVH
`define UPPER_ENVELOPE_LINE_TABLE_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define UELT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define UELT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

### design/uelt_pkg.sv
// Shared types, constants and command codes of the upper envelope line table.
// Used by the divider, datapath, controller and top level; depends on nothing.
package uelt_pkg;

  localparam int MAX_LINES = 64;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);

  localparam int SLOPE_W = 16;
  localparam int ICPT_W  = 32;
  localparam int X_W     = 32;
  localparam int BP_W    = 52;
  localparam int VAL_W   = 63;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SLOPE_W + X_W;

  // Breakpoints saturate at this magnitude.
  localparam logic signed [BP_W-1:0] BP_INF = 52'sd9999999999999;

  // Divider operand widths: intercept difference scaled by 2^16 over slope difference.
  localparam int NUM_W     = ICPT_W + 1 + FRAC_W;
  localparam int DEN_W     = SLOPE_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                      mode;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic signed [X_W-1:0]     query_x;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
  } result_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic signed [BP_W-1:0]    breakpoint;
  } entry_t;

  // Datapath command codes.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH     = 5'd1;
  localparam logic [OP_W-1:0] OP_RD_I      = 5'd2;
  localparam logic [OP_W-1:0] OP_I_INC     = 5'd3;
  localparam logic [OP_W-1:0] OP_Q_HOLD    = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL       = 5'd5;
  localparam logic [OP_W-1:0] OP_ADD       = 5'd6;
  localparam logic [OP_W-1:0] OP_RES_OK    = 5'd7;
  localparam logic [OP_W-1:0] OP_RES_FULL  = 5'd8;
  localparam logic [OP_W-1:0] OP_RES_EMPTY = 5'd9;
  localparam logic [OP_W-1:0] OP_SH_START  = 5'd10;
  localparam logic [OP_W-1:0] OP_SH_RD     = 5'd11;
  localparam logic [OP_W-1:0] OP_SH_WR     = 5'd12;
  localparam logic [OP_W-1:0] OP_WNEW      = 5'd13;
  localparam logic [OP_W-1:0] OP_RD_A      = 5'd14;
  localparam logic [OP_W-1:0] OP_RD_B      = 5'd15;
  localparam logic [OP_W-1:0] OP_GET_B     = 5'd16;
  localparam logic [OP_W-1:0] OP_BP_INF    = 5'd17;
  localparam logic [OP_W-1:0] OP_BP_EQ     = 5'd18;
  localparam logic [OP_W-1:0] OP_DIV       = 5'd19;
  localparam logic [OP_W-1:0] OP_BP_DIV    = 5'd20;
  localparam logic [OP_W-1:0] OP_CUT_WR    = 5'd21;
  localparam logic [OP_W-1:0] OP_RM_START  = 5'd22;
  localparam logic [OP_W-1:0] OP_RM_RD     = 5'd23;
  localparam logic [OP_W-1:0] OP_RM_WR     = 5'd24;
  localparam logic [OP_W-1:0] OP_RM_END    = 5'd25;
  localparam logic [OP_W-1:0] OP_S5        = 5'd26;
  localparam logic [OP_W-1:0] OP_S6        = 5'd27;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic n_zero;
    logic n_full;
    logic i_eq_n;
    logic i_last;
    logic k_le;
    logic bp_lt_x;
    logic j_eq_pos;
    logic j1_ge_n;
    logic b_ge_n;
    logic same_k;
    logic cov;
    logic ge;
    logic x_zero;
    logic y_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### design/uelt_div.sv
// Iterative signed floor divider for breakpoints, one quotient bit per cycle.
// Depends on uelt_pkg for operand widths and the saturation limit.
module uelt_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [uelt_pkg::NUM_W-1:0] num,
  input  logic signed [uelt_pkg::DEN_W-1:0] den,
  output logic                              done,
  output logic signed [uelt_pkg::BP_W-1:0]  quotient
);
  import uelt_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-2:0]     rem;
  logic [DEN_W-2:0]     dmag;
  logic [NUM_W-1:0]     quo;
  logic                 neg;

  logic [NUM_W-1:0]            nmag;
  logic [DEN_W-1:0]            dneg;
  logic [DEN_W-1:0]            r2;
  logic [DEN_W-1:0]            rdiff;
  logic                        fits;
  logic signed [NUM_W+1:0]     qext;
  logic signed [NUM_W+1:0]     qs;
  logic signed [NUM_W+1:0]     lim;

  // Operand magnitudes and one restoring step.
  always_comb begin
    nmag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dneg  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    r2    = {rem, quo[NUM_W-1]};
    rdiff = r2 - {1'b0, dmag};
    fits  = r2 >= {1'b0, dmag};
    qext  = $signed({2'b00, quo});
    qs    = neg ? (-qext - ((rem != '0) ? (NUM_W+2)'(1) : '0)) : qext;
    lim   = (NUM_W+2)'(BP_INF);
  end

  // Sequencing of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - DIV_CNT_W'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, quotient and the floored, saturated result.
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= nmag;
      rem  <= '0;
      dmag <= dneg[DEN_W-2:0];
      neg  <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy && cnt != '0) begin
      rem <= fits ? rdiff[DEN_W-2:0] : r2[DEN_W-2:0];
      quo <= {quo[NUM_W-2:0], fits};
    end else if (busy) begin
      if (qs > lim) begin
        quotient <= BP_INF;
      end else if (qs < -lim) begin
        quotient <= -BP_INF;
      end else begin
        quotient <= BP_W'(qs);
      end
    end
  end

endmodule

### design/uelt_datapath.sv
// Datapath: line table memory, index registers, multiplier, result register.
// Depends on uelt_pkg, uelt_div and the assertion macro header.
`include "upper_envelope_line_table_unit_defines.svh"

module uelt_datapath (
  input  logic              clk,
  input  logic              rst,
  input  uelt_pkg::cmd_t    cmd,
  output uelt_pkg::sts_t    sts,
  input  uelt_pkg::item_t   item,
  output uelt_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);
  import uelt_pkg::*;

  entry_t mem [MAX_LINES];
  entry_t rd_q;

  logic             rd_en;
  logic [CNT_W-1:0] rd_addr;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  entry_t           wr_data;

  item_t                   cur;
  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        i;
  logic [CNT_W-1:0]        j;
  logic [CNT_W-1:0]        x;
  logic [CNT_W-1:0]        y;
  logic [CNT_W-1:0]        a;
  logic [CNT_W-1:0]        b;
  entry_t                  ea;
  entry_t                  eb;
  logic signed [BP_W-1:0]  bp_new;
  logic                    cov;
  logic signed [PROD_W-1:0] prod;

  logic signed [ICPT_W:0]  mdiff;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic                    div_done;
  logic signed [BP_W-1:0]  div_q;

  // Breakpoint divider.
  always_comb begin
    mdiff   = {eb.intercept[ICPT_W-1], eb.intercept} - {ea.intercept[ICPT_W-1], ea.intercept};
    div_num = {mdiff, {FRAC_W{1'b0}}};
    div_den = {ea.slope[SLOPE_W-1], ea.slope} - {eb.slope[SLOPE_W-1], eb.slope};
  end

  uelt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i;
    wr_en   = 1'b0;
    wr_addr = j;
    wr_data = rd_q;
    unique case (cmd.op)
      OP_RD_I: begin
        rd_en = 1'b1;
      end
      OP_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = j - CNT_W'(1);
      end
      OP_SH_WR, OP_RM_WR: begin
        wr_en = 1'b1;
      end
      OP_WNEW: begin
        wr_en   = 1'b1;
        wr_addr = i;
        wr_data = '{slope: cur.slope, intercept: cur.intercept, breakpoint: '0};
      end
      OP_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = a;
      end
      OP_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = b;
      end
      OP_CUT_WR: begin
        wr_en   = 1'b1;
        wr_addr = a;
        wr_data = '{slope: ea.slope, intercept: ea.intercept, breakpoint: bp_new};
      end
      OP_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = j + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Line table memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  // Line count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      n            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_WNEW:   n <= n + CNT_W'(1);
        OP_RM_END: n <= n - CNT_W'(1);
        OP_ADD, OP_RES_OK, OP_RES_FULL, OP_RES_EMPTY: result_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        cur <= item;
        i   <= '0;
      end
      OP_I_INC:  i  <= i + CNT_W'(1);
      OP_Q_HOLD: ea <= rd_q;
      OP_MUL:    prod <= PROD_W'(ea.slope) * PROD_W'(cur.query_x);
      OP_ADD: begin
        result.value  <= {{(VAL_W-PROD_W){prod[PROD_W-1]}}, prod}
                       + {{(VAL_W-ICPT_W-FRAC_W){ea.intercept[ICPT_W-1]}}, ea.intercept,
                          {FRAC_W{1'b0}}};
        result.status <= STATUS_OK;
      end
      OP_RES_OK: begin
        result.value  <= '0;
        result.status <= STATUS_OK;
      end
      OP_RES_FULL: begin
        result.value  <= '0;
        result.status <= STATUS_FULL;
      end
      OP_RES_EMPTY: begin
        result.value  <= '0;
        result.status <= STATUS_EMPTY;
      end
      OP_SH_START: j <= n;
      OP_SH_WR:    j <= j - CNT_W'(1);
      OP_WNEW: begin
        y <= i;
        a <= i;
        b <= i + CNT_W'(1);
      end
      OP_RD_B:   ea <= rd_q;
      OP_GET_B:  eb <= rd_q;
      OP_BP_INF: bp_new <= BP_INF;
      OP_BP_EQ:  bp_new <= ($signed(ea.intercept) > $signed(eb.intercept)) ? BP_INF : -BP_INF;
      OP_BP_DIV: bp_new <= div_q;
      OP_CUT_WR: cov <= (b < n) && ($signed(bp_new) >= $signed(eb.breakpoint));
      OP_RM_START: j <= b;
      OP_RM_WR:    j <= j + CNT_W'(1);
      OP_S5: begin
        x <= y - CNT_W'(1);
        a <= y - CNT_W'(1);
        b <= y;
      end
      OP_S6: begin
        y <= x;
        x <= x - CNT_W'(1);
        a <= x - CNT_W'(1);
        b <= x;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts.mode     = cur.mode;
    sts.n_zero   = (n == '0);
    sts.n_full   = (n == CNT_W'(MAX_LINES));
    sts.i_eq_n   = (i == n);
    sts.i_last   = ({1'b0, i} + (CNT_W+1)'(1)) >= {1'b0, n};
    sts.k_le     = $signed(rd_q.slope) <= $signed(cur.slope);
    sts.bp_lt_x  = $signed(rd_q.breakpoint) < $signed(BP_W'(cur.query_x));
    sts.j_eq_pos = (j == i);
    sts.j1_ge_n  = ({1'b0, j} + (CNT_W+1)'(1)) >= {1'b0, n};
    sts.b_ge_n   = (b >= n);
    sts.same_k   = (ea.slope == eb.slope);
    sts.cov      = cov;
    sts.ge       = $signed(ea.breakpoint) >= $signed(eb.breakpoint);
    sts.x_zero   = (x == '0);
    sts.y_zero   = (y == '0);
    sts.div_done = div_done;
    sts.out_free = !result_valid || result_ready;
  end

  // Checks on table bookkeeping.
  `UELT_ASSERT_ALWAYS(a_count_in_range, n <= CNT_W'(MAX_LINES), "line count above table size")
  `UELT_ASSERT_IMP(a_no_insert_full, cmd.op == OP_WNEW, n != CNT_W'(MAX_LINES), "insert into full table")
  `UELT_ASSERT_IMP(a_cut_in_table, cmd.op == OP_CUT_WR, a < n, "breakpoint written outside table")
  `UELT_ASSERT_IMP(a_result_free, cmd.op == OP_ADD, !result_valid || result_ready, "result overwritten")

endmodule

### design/uelt_ctrl.sv
// Controller state machine sequencing queries, inserts, cuts and removals.
// Depends on uelt_pkg for command codes and the status struct.
module uelt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  uelt_pkg::sts_t sts,
  output uelt_pkg::cmd_t cmd
);
  import uelt_pkg::*;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DISP     = 5'd1;
  localparam logic [4:0] ST_EMPTY    = 5'd2;
  localparam logic [4:0] ST_FULL     = 5'd3;
  localparam logic [4:0] ST_Q_RD     = 5'd4;
  localparam logic [4:0] ST_Q_CHK    = 5'd5;
  localparam logic [4:0] ST_Q_MUL    = 5'd6;
  localparam logic [4:0] ST_Q_ADD    = 5'd7;
  localparam logic [4:0] ST_F_RD     = 5'd8;
  localparam logic [4:0] ST_F_CHK    = 5'd9;
  localparam logic [4:0] ST_SH_RD    = 5'd10;
  localparam logic [4:0] ST_SH_WR    = 5'd11;
  localparam logic [4:0] ST_WNEW     = 5'd12;
  localparam logic [4:0] ST_C_RDA    = 5'd13;
  localparam logic [4:0] ST_C_RDB    = 5'd14;
  localparam logic [4:0] ST_C_GETB   = 5'd15;
  localparam logic [4:0] ST_C_CALC   = 5'd16;
  localparam logic [4:0] ST_C_DIV    = 5'd17;
  localparam logic [4:0] ST_C_WR     = 5'd18;
  localparam logic [4:0] ST_C_NEXT   = 5'd19;
  localparam logic [4:0] ST_RM_RD    = 5'd20;
  localparam logic [4:0] ST_RM_WR    = 5'd21;
  localparam logic [4:0] ST_S5       = 5'd22;
  localparam logic [4:0] ST_S6       = 5'd23;
  localparam logic [4:0] ST_CMP      = 5'd24;
  localparam logic [4:0] ST_INS_DONE = 5'd25;

  // Which part of the insert a shared cut or removal belongs to.
  localparam logic [2:0] PH_S4  = 3'd0;
  localparam logic [2:0] PH_S5A = 3'd1;
  localparam logic [2:0] PH_S5B = 3'd2;
  localparam logic [2:0] PH_S6  = 3'd3;
  localparam logic [2:0] PH_S6C = 3'd4;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [2:0] phase;
  logic [2:0] phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_S4;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and command.
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op     = OP_NONE;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.mode == MODE_QUERY) begin
          state_next = sts.n_zero ? ST_EMPTY : ST_Q_RD;
        end else begin
          state_next = sts.n_full ? ST_FULL : ST_F_RD;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.op     = OP_RES_EMPTY;
          state_next = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (sts.out_free) begin
          cmd.op     = OP_RES_FULL;
          state_next = ST_IDLE;
        end
      end
      ST_Q_RD: begin
        cmd.op     = OP_RD_I;
        state_next = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        if (!sts.i_last && sts.bp_lt_x) begin
          cmd.op     = OP_I_INC;
          state_next = ST_Q_RD;
        end else begin
          cmd.op     = OP_Q_HOLD;
          state_next = ST_Q_MUL;
        end
      end
      ST_Q_MUL: begin
        cmd.op     = OP_MUL;
        state_next = ST_Q_ADD;
      end
      ST_Q_ADD: begin
        if (sts.out_free) begin
          cmd.op     = OP_ADD;
          state_next = ST_IDLE;
        end
      end
      ST_F_RD: begin
        if (sts.i_eq_n) begin
          cmd.op     = OP_SH_START;
          state_next = ST_SH_RD;
        end else begin
          cmd.op     = OP_RD_I;
          state_next = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (sts.k_le) begin
          cmd.op     = OP_I_INC;
          state_next = ST_F_RD;
        end else begin
          cmd.op     = OP_SH_START;
          state_next = ST_SH_RD;
        end
      end
      ST_SH_RD: begin
        if (sts.j_eq_pos) begin
          state_next = ST_WNEW;
        end else begin
          cmd.op     = OP_SH_RD;
          state_next = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd.op     = OP_SH_WR;
        state_next = ST_SH_RD;
      end
      ST_WNEW: begin
        cmd.op     = OP_WNEW;
        phase_next = PH_S4;
        state_next = ST_C_RDA;
      end
      ST_C_RDA: begin
        cmd.op     = OP_RD_A;
        state_next = ST_C_RDB;
      end
      ST_C_RDB: begin
        cmd.op     = OP_RD_B;
        state_next = ST_C_GETB;
      end
      ST_C_GETB: begin
        cmd.op     = OP_GET_B;
        state_next = (phase == PH_S6) ? ST_CMP : ST_C_CALC;
      end
      ST_CMP: begin
        if (sts.ge) begin
          cmd.op     = OP_RM_START;
          phase_next = PH_S6C;
          state_next = ST_RM_RD;
        end else begin
          state_next = ST_INS_DONE;
        end
      end
      ST_C_CALC: begin
        if (sts.b_ge_n) begin
          cmd.op     = OP_BP_INF;
          state_next = ST_C_WR;
        end else if (sts.same_k) begin
          cmd.op     = OP_BP_EQ;
          state_next = ST_C_WR;
        end else begin
          cmd.op     = OP_DIV;
          state_next = ST_C_DIV;
        end
      end
      ST_C_DIV: begin
        if (sts.div_done) begin
          cmd.op     = OP_BP_DIV;
          state_next = ST_C_WR;
        end
      end
      ST_C_WR: begin
        cmd.op     = OP_CUT_WR;
        state_next = ST_C_NEXT;
      end
      ST_C_NEXT: begin
        if ((phase == PH_S4 || phase == PH_S5A) && sts.cov) begin
          cmd.op     = OP_RM_START;
          state_next = ST_RM_RD;
        end else if (phase == PH_S4) begin
          state_next = ST_S5;
        end else begin
          state_next = ST_S6;
        end
      end
      ST_RM_RD: begin
        if (sts.j1_ge_n) begin
          cmd.op     = OP_RM_END;
          state_next = ST_C_RDA;
          if (phase == PH_S5A) begin
            phase_next = PH_S5B;
          end
        end else begin
          cmd.op     = OP_RM_RD;
          state_next = ST_RM_WR;
        end
      end
      ST_RM_WR: begin
        cmd.op     = OP_RM_WR;
        state_next = ST_RM_RD;
      end
      ST_S5: begin
        if (sts.y_zero) begin
          state_next = ST_INS_DONE;
        end else begin
          cmd.op     = OP_S5;
          phase_next = PH_S5A;
          state_next = ST_C_RDA;
        end
      end
      ST_S6: begin
        if (sts.x_zero) begin
          state_next = ST_INS_DONE;
        end else begin
          cmd.op     = OP_S6;
          phase_next = PH_S6;
          state_next = ST_C_RDA;
        end
      end
      ST_INS_DONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_RES_OK;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/upper_envelope_line_table_unit.sv
// Upper envelope line table: keeps up to MAX_LINES lines sorted by slope with
// their Q.16 breakpoints and answers max queries at Q16.16 x. One item is
// handled at a time through a single-port table memory with registered reads.
// A query walks the table with a read-and-compare step per entry up to the
// answering line, then multiplies and adds. An insert walks the table over
// entries of equal or smaller slope, shifts it open, then runs breakpoint
// cuts, using the bit-serial divider where the two slopes differ, and
// removals that move entries down. The result register lets a new item be
// taken while the previous result still waits. No clearing pass after reset.
module upper_envelope_line_table_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  uelt_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output uelt_pkg::result_t result
);
  import uelt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  uelt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  uelt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
